[design/gtpv2c_response_ie_extractor_macros.svh]
// Assertion macros used by the checker file of the IE extractor.
`ifndef GTPV2C_RESPONSE_IE_EXTRACTOR_MACROS_SVH
`define GTPV2C_RESPONSE_IE_EXTRACTOR_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define GTPIE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");

// Checked on every rising clock edge, reset included.
`define GTPIE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("%m: check failed");

`endif

[design/gtpie_pkg.sv]
`default_nettype none
package gtpie_pkg;

    localparam int OFFSET_W = 17;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 17'h1FFFF;
    localparam logic [OFFSET_W-1:0] HEADER_BYTES = 17'd12;

    // Header byte positions.
    localparam logic [OFFSET_W-1:0] HDR_POS_TYPE      = 17'd1;
    localparam logic [OFFSET_W-1:0] HDR_POS_LEN_HI    = 17'd2;
    localparam logic [OFFSET_W-1:0] HDR_POS_LEN_LO    = 17'd3;
    localparam logic [OFFSET_W-1:0] HDR_POS_SEQ_FIRST = 17'd8;
    localparam logic [OFFSET_W-1:0] HDR_POS_SEQ_LAST  = 17'd10;
    localparam logic [OFFSET_W-1:0] HDR_POS_FINAL     = 17'd11;

    // Byte positions within one IE.
    localparam logic [3:0] IE_POS_TYPE     = 4'd0;
    localparam logic [3:0] IE_POS_LEN_HI   = 4'd1;
    localparam logic [3:0] IE_POS_LEN_LO   = 4'd2;
    localparam logic [3:0] IE_POS_FLAGS    = 4'd4;
    localparam logic [3:0] IE_POS_W1_FIRST = 4'd5;
    localparam logic [3:0] IE_POS_W1_LAST  = 4'd8;
    localparam logic [3:0] IE_POS_W2_FIRST = 4'd9;
    localparam logic [3:0] IE_POS_W2_LAST  = 4'd12;
    localparam logic [3:0] IE_POS_MAX      = 4'd15;

    localparam logic [7:0] TYPE_CREATE_RSP = 8'd33;
    localparam logic [7:0] TYPE_MODIFY_RSP = 8'd35;
    localparam logic [7:0] IE_TYPE_FTEID   = 8'd87;
    localparam logic [7:0] IE_PAA          = 8'd79;
    localparam logic [7:0] IE_EBI          = 8'd73;
    localparam logic [7:0] IE_BEARER_CTX   = 8'd93;
    localparam logic [5:0] IFTYPE_S1U      = 6'd1;
    localparam logic [5:0] IFTYPE_S11      = 6'd11;

    localparam logic [15:0] MIN_LEN_WORD_ONE = 16'd5;
    localparam logic [15:0] MIN_LEN_WORD_TWO = 16'd9;

    localparam logic [2:0] STATUS_CREATE    = 3'd0;
    localparam logic [2:0] STATUS_MODIFY    = 3'd1;
    localparam logic [2:0] STATUS_NACK      = 3'd2;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    localparam int FOUND_S1U = 0;
    localparam int FOUND_S11 = 1;
    localparam int FOUND_PAA = 2;
    localparam int FOUND_EBI = 3;

    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_WALK   = 4'b0010,
        MODE_DONE   = 4'b0100,
        MODE_DUP    = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  found_mask;
        logic [31:0] s1u_teid;
        logic [31:0] sgw_ipv4;
        logic [31:0] s11_teid;
        logic [31:0] ue_ipv4;
        logic [7:0]  bearer_id;
    } t_result;

endpackage
`default_nettype wire

[design/gtpv2c_response_ie_extractor.sv]
`default_nettype none
// GTPv2-C response IE extractor: takes one message byte per cycle with no gaps
// of its own, since every byte passes the header and IE-walk logic once. After
// the final byte of a message it presents one result word (status, found mask
// and the extracted TEIDs, addresses and bearer id) from the result register,
// which loads it when the core takes that byte from the input register. Each
// byte passes an input register, the combinational header and IE-walk logic,
// and a result register. The input stalls only while a final
// byte sits in the input register and the previous result word has not been
// taken yet; otherwise bytes flow at one per cycle regardless of the output side.
module gtpv2c_response_ie_extractor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_found_mask,
    output logic [31:0] o_s1u_teid,
    output logic [31:0] o_sgw_ipv4,
    output logic [31:0] o_s11_teid,
    output logic [31:0] o_ue_ipv4,
    output logic [7:0]  o_bearer_id
);

    gtpie_pkg::t_in_word in_word;
    gtpie_pkg::t_in_word held_word;
    gtpie_pkg::t_result  core_res;
    gtpie_pkg::t_result  out_res;
    logic                held_valid;
    logic                take;
    logic                res_valid;

    assign in_word.data_byte = i_data_byte;
    assign in_word.last_byte = i_last_byte;

    // A final byte needs a free result slot, or one being emptied this cycle.
    assign take = held_valid && (!held_word.last_byte || !o_out_valid || i_out_ready);

    gtpie_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    gtpie_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (take),
        .i_word      (held_word),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    gtpie_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (core_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_status     = out_res.status;
    assign o_found_mask = out_res.found_mask;
    assign o_s1u_teid   = out_res.s1u_teid;
    assign o_sgw_ipv4   = out_res.sgw_ipv4;
    assign o_s11_teid   = out_res.s11_teid;
    assign o_ue_ipv4    = out_res.ue_ipv4;
    assign o_bearer_id  = out_res.bearer_id;

endmodule
`default_nettype wire

[design/gtpie_in_reg.sv]
`default_nettype none
module gtpie_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire gtpie_pkg::t_in_word i_word,
    input  wire                   i_take,
    output logic                  o_valid,
    output gtpie_pkg::t_in_word   o_word
);

    logic                r_valid;
    gtpie_pkg::t_in_word r_word;

    // The register frees up in the same cycle the core consumes its word.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule
`default_nettype wire

[design/gtpie_core.sv]
`default_nettype none
module gtpie_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_proc,
    input  wire gtpie_pkg::t_in_word i_word,
    output logic                     o_res_valid,
    output gtpie_pkg::t_result       o_res
);

    localparam int OW = gtpie_pkg::OFFSET_W;

    function automatic logic [OW-1:0] sat_offset(input logic [OW:0] v);
        logic [OW-1:0] r;
        r = (v > {1'b0, gtpie_pkg::OFFSET_MAX}) ? gtpie_pkg::OFFSET_MAX : v[OW-1:0];
        return r;
    endfunction

    logic [OW-1:0]    r_offset, n_offset;
    logic [7:0]       r_msg_type, n_msg_type;
    logic [15:0]      r_msg_len, n_msg_len;
    logic [23:0]      r_seq, n_seq;
    logic [23:0]      r_last_seq, n_last_seq;
    gtpie_pkg::t_mode r_mode, n_mode;
    logic [OW-1:0]    r_next_ie, n_next_ie;
    logic [7:0]       r_ie_type, n_ie_type;
    logic [15:0]      r_ie_len, n_ie_len;
    logic [7:0]       r_ie_flags, n_ie_flags;
    logic [31:0]      r_w1, n_w1;
    logic [31:0]      r_w2, n_w2;
    logic [3:0]       r_ie_pos, n_ie_pos;
    logic [31:0]      r_s1u, n_s1u;
    logic [31:0]      r_sgw, n_sgw;
    logic [31:0]      r_s11, n_s11;
    logic [31:0]      r_ue, n_ue;
    logic [7:0]       r_ebi, n_ebi;
    logic [3:0]       r_found, n_found;

    logic [7:0]    b;
    logic [OW-1:0] p;
    logic [OW-1:0] walk_bound;
    logic          ie_start;
    logic [3:0]    pos_cur;
    logic [15:0]   len_new;
    logic [31:0]   w1_new;
    logic [31:0]   w2_new;
    logic [2:0]    status;

    assign b          = i_word.data_byte;
    assign p          = r_offset;
    assign walk_bound = {1'b0, r_msg_len} + 17'd4;
    assign ie_start   = (p == r_next_ie);
    assign pos_cur    = ie_start ? gtpie_pkg::IE_POS_TYPE :
                        (r_ie_pos < gtpie_pkg::IE_POS_MAX) ? r_ie_pos + 4'd1 : r_ie_pos;
    assign len_new    = {r_ie_len[15:8], b};
    assign w1_new     = {r_w1[23:0], b};
    assign w2_new     = {r_w2[23:0], b};

    always_comb begin
        n_offset   = sat_offset({1'b0, p} + 18'd1);
        n_msg_type = r_msg_type;
        n_msg_len  = r_msg_len;
        n_seq      = r_seq;
        n_last_seq = r_last_seq;
        n_mode     = r_mode;
        n_next_ie  = r_next_ie;
        n_ie_type  = r_ie_type;
        n_ie_len   = r_ie_len;
        n_ie_flags = r_ie_flags;
        n_w1       = r_w1;
        n_w2       = r_w2;
        n_ie_pos   = r_ie_pos;
        n_s1u      = r_s1u;
        n_sgw      = r_sgw;
        n_s11      = r_s11;
        n_ue       = r_ue;
        n_ebi      = r_ebi;
        n_found    = r_found;

        case (r_mode)
            gtpie_pkg::MODE_HEADER: begin
                if (p == gtpie_pkg::HDR_POS_TYPE) begin
                    n_msg_type = b;
                end else if (p == gtpie_pkg::HDR_POS_LEN_HI) begin
                    n_msg_len = {b, 8'h00};
                end else if (p == gtpie_pkg::HDR_POS_LEN_LO) begin
                    n_msg_len = {r_msg_len[15:8], b};
                end else if (p >= gtpie_pkg::HDR_POS_SEQ_FIRST &&
                             p <= gtpie_pkg::HDR_POS_SEQ_LAST) begin
                    n_seq = {r_seq[15:0], b};
                end else if (p == gtpie_pkg::HDR_POS_FINAL) begin
                    if (r_seq == r_last_seq) begin
                        n_mode = gtpie_pkg::MODE_DUP;
                    end else begin
                        n_last_seq = r_seq;
                        if (r_msg_type == gtpie_pkg::TYPE_CREATE_RSP ||
                            r_msg_type == gtpie_pkg::TYPE_MODIFY_RSP) begin
                            n_mode = gtpie_pkg::MODE_WALK;
                        end else begin
                            n_mode = gtpie_pkg::MODE_DONE;
                        end
                    end
                end
            end
            gtpie_pkg::MODE_WALK: begin
                // An IE that would start at or past the end of the message ends the walk.
                if (ie_start && p >= walk_bound) begin
                    n_mode = gtpie_pkg::MODE_DONE;
                end else begin
                    n_ie_pos = pos_cur;
                    if (pos_cur == gtpie_pkg::IE_POS_TYPE) begin
                        n_ie_type = b;
                    end else if (pos_cur == gtpie_pkg::IE_POS_LEN_HI) begin
                        n_ie_len = {b, 8'h00};
                    end else if (pos_cur == gtpie_pkg::IE_POS_LEN_LO) begin
                        n_ie_len = len_new;
                        if (len_new == 16'd0) begin
                            n_mode = gtpie_pkg::MODE_DONE;
                        end else if (r_ie_type == gtpie_pkg::IE_BEARER_CTX) begin
                            // Step into the grouped IE: its first child follows the header.
                            n_next_ie = sat_offset({1'b0, p} + 18'd2);
                        end else begin
                            n_next_ie = sat_offset({1'b0, p} + {2'b00, len_new} + 18'd2);
                        end
                    end else if (pos_cur == gtpie_pkg::IE_POS_FLAGS) begin
                        n_ie_flags = b;
                        if (r_ie_type == gtpie_pkg::IE_EBI) begin
                            n_ebi = b;
                            n_found[gtpie_pkg::FOUND_EBI] = 1'b1;
                        end
                    end else if (pos_cur >= gtpie_pkg::IE_POS_W1_FIRST &&
                                 pos_cur <= gtpie_pkg::IE_POS_W1_LAST) begin
                        n_w1 = w1_new;
                        if (pos_cur == gtpie_pkg::IE_POS_W1_LAST &&
                            r_ie_len >= gtpie_pkg::MIN_LEN_WORD_ONE) begin
                            if (r_ie_type == gtpie_pkg::IE_TYPE_FTEID &&
                                r_ie_flags[5:0] == gtpie_pkg::IFTYPE_S11) begin
                                n_s11 = w1_new;
                                n_found[gtpie_pkg::FOUND_S11] = 1'b1;
                            end else if (r_ie_type == gtpie_pkg::IE_PAA) begin
                                n_ue = w1_new;
                                n_found[gtpie_pkg::FOUND_PAA] = 1'b1;
                            end
                        end
                    end else if (pos_cur >= gtpie_pkg::IE_POS_W2_FIRST &&
                                 pos_cur <= gtpie_pkg::IE_POS_W2_LAST) begin
                        n_w2 = w2_new;
                        if (pos_cur == gtpie_pkg::IE_POS_W2_LAST &&
                            r_ie_len >= gtpie_pkg::MIN_LEN_WORD_TWO &&
                            r_ie_type == gtpie_pkg::IE_TYPE_FTEID &&
                            r_ie_flags[5:0] == gtpie_pkg::IFTYPE_S1U) begin
                            n_s1u = r_w1;
                            n_sgw = w2_new;
                            n_found[gtpie_pkg::FOUND_S1U] = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (n_mode == gtpie_pkg::MODE_HEADER) begin
            status = gtpie_pkg::STATUS_TRUNCATED;
        end else if (n_mode == gtpie_pkg::MODE_DUP) begin
            status = gtpie_pkg::STATUS_DUPLICATE;
        end else if (n_msg_type == gtpie_pkg::TYPE_CREATE_RSP) begin
            status = gtpie_pkg::STATUS_CREATE;
        end else if (n_msg_type == gtpie_pkg::TYPE_MODIFY_RSP) begin
            status = gtpie_pkg::STATUS_MODIFY;
        end else begin
            status = gtpie_pkg::STATUS_NACK;
        end

        o_res.status     = status;
        o_res.found_mask = n_found;
        o_res.s1u_teid   = n_s1u;
        o_res.sgw_ipv4   = n_sgw;
        o_res.s11_teid   = n_s11;
        o_res.ue_ipv4    = n_ue;
        o_res.bearer_id  = n_ebi;

        // The final byte closes the message; only the stored sequence survives.
        if (i_word.last_byte) begin
            n_offset   = '0;
            n_msg_type = '0;
            n_msg_len  = '0;
            n_seq      = '0;
            n_mode     = gtpie_pkg::MODE_HEADER;
            n_next_ie  = gtpie_pkg::HEADER_BYTES;
            n_ie_type  = '0;
            n_ie_len   = '0;
            n_ie_flags = '0;
            n_w1       = '0;
            n_w2       = '0;
            n_ie_pos   = '0;
            n_s1u      = '0;
            n_sgw      = '0;
            n_s11      = '0;
            n_ue       = '0;
            n_ebi      = '0;
            n_found    = '0;
        end
    end

    assign o_res_valid = i_proc && i_word.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_msg_type <= '0;
            r_msg_len  <= '0;
            r_seq      <= '0;
            r_last_seq <= '0;
            r_mode     <= gtpie_pkg::MODE_HEADER;
            r_next_ie  <= gtpie_pkg::HEADER_BYTES;
            r_ie_type  <= '0;
            r_ie_len   <= '0;
            r_ie_flags <= '0;
            r_w1       <= '0;
            r_w2       <= '0;
            r_ie_pos   <= '0;
            r_s1u      <= '0;
            r_sgw      <= '0;
            r_s11      <= '0;
            r_ue       <= '0;
            r_ebi      <= '0;
            r_found    <= '0;
        end else if (i_proc) begin
            r_offset   <= n_offset;
            r_msg_type <= n_msg_type;
            r_msg_len  <= n_msg_len;
            r_seq      <= n_seq;
            r_last_seq <= n_last_seq;
            r_mode     <= n_mode;
            r_next_ie  <= n_next_ie;
            r_ie_type  <= n_ie_type;
            r_ie_len   <= n_ie_len;
            r_ie_flags <= n_ie_flags;
            r_w1       <= n_w1;
            r_w2       <= n_w2;
            r_ie_pos   <= n_ie_pos;
            r_s1u      <= n_s1u;
            r_sgw      <= n_sgw;
            r_s11      <= n_s11;
            r_ue       <= n_ue;
            r_ebi      <= n_ebi;
            r_found    <= n_found;
        end
    end

endmodule
`default_nettype wire

[design/gtpie_out_reg.sv]
`default_nettype none
module gtpie_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire gtpie_pkg::t_result i_res,
    output logic                    o_valid,
    input  wire                     i_ready,
    output gtpie_pkg::t_result      o_res
);

    logic               r_valid;
    gtpie_pkg::t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

[design/gtpie_checker.sv]
`default_nettype none
`include "gtpv2c_response_ie_extractor_macros.svh"
module gtpie_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  o_status,
    input wire [3:0]  o_found_mask,
    input wire [31:0] o_s1u_teid,
    input wire [31:0] o_sgw_ipv4,
    input wire [31:0] o_s11_teid,
    input wire [31:0] o_ue_ipv4,
    input wire [7:0]  o_bearer_id
);

    logic walked;
    logic values_clear;

    assign walked = (o_status == gtpie_pkg::STATUS_CREATE) ||
                    (o_status == gtpie_pkg::STATUS_MODIFY);
    assign values_clear = (o_found_mask == 4'd0) && (o_s1u_teid == 32'd0) &&
                          (o_s11_teid == 32'd0) && (o_ue_ipv4 == 32'd0) &&
                          (o_bearer_id == 8'd0);

    // A result word stays put until it is taken.
    `GTPIE_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))

    // Nothing is extracted unless the message was a create or modify response.
    `GTPIE_ASSERT(a_no_walk_no_data, o_out_valid && !walked |-> values_clear)

    // The S1-U fields are only loaded together with their found bit.
    `GTPIE_ASSERT(a_s1u_found, o_out_valid && !o_found_mask[gtpie_pkg::FOUND_S1U] |-> o_s1u_teid == 32'd0 && o_sgw_ipv4 == 32'd0)

    // No result word survives a reset.
    `GTPIE_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule

bind gtpv2c_response_ie_extractor gtpie_checker u_gtpie_checker (.*);
`default_nettype wire

[tb/gtpv2c_response_ie_extractor_tb.sv]
module gtpv2c_response_ie_extractor_tb;
    import gtpie_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_BYTES   = 110;

    localparam int KIND_GOOD    = 0;
    localparam int KIND_NACK    = 1;
    localparam int KIND_DUP     = 2;
    localparam int KIND_TRUNC   = 3;
    localparam int KIND_BAD_LEN = 4;
    localparam int KIND_CUT     = 5;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_ready = 1'b0;

    wire        o_in_ready;
    wire        o_out_valid;
    wire [2:0]  o_status;
    wire [3:0]  o_found_mask;
    wire [31:0] o_s1u_teid;
    wire [31:0] o_sgw_ipv4;
    wire [31:0] o_s11_teid;
    wire [31:0] o_ue_ipv4;
    wire [7:0]  o_bearer_id;

    t_in_word   pending_words[$];
    t_result    expected_results[$];
    t_result    want;
    logic [7:0] msg[$];
    logic [23:0] recent_seq = 24'h0;
    int         bytes_queued = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_request = 1'b0;
    int         hold_left = 0;
    int         failures = 0;
    int         cycle_count = 0;

    // Decoder state of the predictor.
    logic [16:0] pos_r;
    logic [7:0]  msg_type_r;
    logic [15:0] msg_len_r;
    logic [23:0] seq_acc_r;
    logic [23:0] last_seq_r;
    t_mode       mode_r;
    logic [16:0] next_ie_r;
    logic [7:0]  ie_type_r;
    logic [15:0] ie_len_r;
    logic [7:0]  ie_flags_r;
    logic [31:0] word1_r;
    logic [31:0] word2_r;
    logic [3:0]  ie_pos_r;
    t_result     held_r;

    gtpv2c_response_ie_extractor i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (data_byte),
        .i_last_byte  (last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_status     (o_status),
        .o_found_mask (o_found_mask),
        .o_s1u_teid   (o_s1u_teid),
        .o_sgw_ipv4   (o_sgw_ipv4),
        .o_s11_teid   (o_s11_teid),
        .o_ue_ipv4    (o_ue_ipv4),
        .o_bearer_id  (o_bearer_id)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [16:0] sat_offset(input int v);
        if (v > int'(OFFSET_MAX)) begin
            return OFFSET_MAX;
        end
        return v[16:0];
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    function automatic logic [23:0] fresh_seq();
        logic [23:0] s;
        s = 24'($urandom);
        if (s == recent_seq) begin
            s = s ^ 24'h000001;
        end
        return s;
    endfunction

    // Everything but the stored sequence starts over with each message.
    function void clear_message();
        pos_r      = '0;
        msg_type_r = '0;
        msg_len_r  = '0;
        seq_acc_r  = '0;
        mode_r     = MODE_HEADER;
        next_ie_r  = HEADER_BYTES;
        ie_type_r  = '0;
        ie_len_r   = '0;
        ie_flags_r = '0;
        word1_r    = '0;
        word2_r    = '0;
        ie_pos_r   = '0;
        held_r     = '0;
    endfunction

    task decode_byte(input logic [7:0] b, input logic fin);
        int      p;
        int      start;
        t_result res;
        p = pos_r;
        if (mode_r == MODE_HEADER) begin
            if (p == HDR_POS_TYPE) begin
                msg_type_r = b;
            end else if (p == HDR_POS_LEN_HI) begin
                msg_len_r = {b, 8'h00};
            end else if (p == HDR_POS_LEN_LO) begin
                msg_len_r[7:0] = b;
            end else if (p >= HDR_POS_SEQ_FIRST && p <= HDR_POS_SEQ_LAST) begin
                seq_acc_r = {seq_acc_r[15:0], b};
            end else if (p == HDR_POS_FINAL) begin
                if (seq_acc_r == last_seq_r) begin
                    mode_r = MODE_DUP;
                end else begin
                    last_seq_r = seq_acc_r;
                    if (msg_type_r == TYPE_CREATE_RSP || msg_type_r == TYPE_MODIFY_RSP) begin
                        mode_r = MODE_WALK;
                    end else begin
                        mode_r = MODE_DONE;
                    end
                end
            end
        end else if (mode_r == MODE_WALK) begin
            if (p == next_ie_r && p >= msg_len_r + 4) begin
                mode_r = MODE_DONE;
            end else begin
                if (p == next_ie_r) begin
                    ie_pos_r = IE_POS_TYPE;
                end else if (ie_pos_r < IE_POS_MAX) begin
                    ie_pos_r = ie_pos_r + 4'd1;
                end
                case (ie_pos_r)
                    IE_POS_TYPE: begin
                        ie_type_r = b;
                    end
                    IE_POS_LEN_HI: begin
                        ie_len_r = {b, 8'h00};
                    end
                    IE_POS_LEN_LO: begin
                        start = p - 2;
                        ie_len_r[7:0] = b;
                        if (ie_len_r == 16'd0) begin
                            mode_r = MODE_DONE;
                        end else if (ie_type_r == IE_BEARER_CTX) begin
                            // A bearer context is entered: its children follow its header.
                            next_ie_r = sat_offset(start + 4);
                        end else begin
                            next_ie_r = sat_offset(start + ie_len_r + 4);
                        end
                    end
                    IE_POS_FLAGS: begin
                        ie_flags_r = b;
                        if (ie_type_r == IE_EBI) begin
                            held_r.bearer_id = b;
                            held_r.found_mask[FOUND_EBI] = 1'b1;
                        end
                    end
                    default: begin
                        if (ie_pos_r >= IE_POS_W1_FIRST && ie_pos_r <= IE_POS_W1_LAST) begin
                            word1_r = {word1_r[23:0], b};
                            if (ie_pos_r == IE_POS_W1_LAST && ie_len_r >= MIN_LEN_WORD_ONE) begin
                                if (ie_type_r == IE_TYPE_FTEID &&
                                    ie_flags_r[5:0] == IFTYPE_S11) begin
                                    held_r.s11_teid = word1_r;
                                    held_r.found_mask[FOUND_S11] = 1'b1;
                                end else if (ie_type_r == IE_PAA) begin
                                    held_r.ue_ipv4 = word1_r;
                                    held_r.found_mask[FOUND_PAA] = 1'b1;
                                end
                            end
                        end else if (ie_pos_r >= IE_POS_W2_FIRST &&
                                     ie_pos_r <= IE_POS_W2_LAST) begin
                            word2_r = {word2_r[23:0], b};
                            if (ie_pos_r == IE_POS_W2_LAST && ie_len_r >= MIN_LEN_WORD_TWO &&
                                ie_type_r == IE_TYPE_FTEID &&
                                ie_flags_r[5:0] == IFTYPE_S1U) begin
                                held_r.s1u_teid = word1_r;
                                held_r.sgw_ipv4 = word2_r;
                                held_r.found_mask[FOUND_S1U] = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        pos_r = sat_offset(p + 1);
        if (fin) begin
            res = held_r;
            if (mode_r == MODE_HEADER) begin
                res.status = STATUS_TRUNCATED;
            end else if (mode_r == MODE_DUP) begin
                res.status = STATUS_DUPLICATE;
            end else if (msg_type_r == TYPE_CREATE_RSP) begin
                res.status = STATUS_CREATE;
            end else if (msg_type_r == TYPE_MODIFY_RSP) begin
                res.status = STATUS_MODIFY;
            end else begin
                res.status = STATUS_NACK;
            end
            expected_results.push_back(res);
            clear_message();
        end
    endtask

    task put_header(input logic [7:0] mtype, input logic [23:0] seq);
        msg.push_back(rand_byte());
        msg.push_back(mtype);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        repeat (4) msg.push_back(rand_byte());
        msg.push_back(seq[23:16]);
        msg.push_back(seq[15:8]);
        msg.push_back(seq[7:0]);
        msg.push_back(rand_byte());
        recent_seq = seq;
    endtask

    task set_length(input int len);
        msg[2] = len[15:8];
        msg[3] = len[7:0];
    endtask

    // The body is filled from the nine leading bytes given, then random padding.
    task put_value_ie(input logic [7:0] t, input int len, input logic [71:0] body);
        int i;
        msg.push_back(t);
        msg.push_back(len[15:8]);
        msg.push_back(len[7:0]);
        msg.push_back(rand_byte());
        for (i = 0; i < len; i++) begin
            msg.push_back(i < 9 ? body[71 - 8 * i -: 8] : rand_byte());
        end
    endtask

    task open_bearer(output int at);
        at = msg.size();
        msg.push_back(IE_BEARER_CTX);
        msg.push_back(8'h00);
        msg.push_back(8'h00);
        msg.push_back(rand_byte());
    endtask

    task close_bearer(input int at);
        int len;
        len = msg.size() - at - 4;
        msg[at + 1] = len[15:8];
        msg[at + 2] = len[7:0];
    endtask

    task put_leaf_ie();
        int         odd_len;
        bit         use_odd;
        logic [1:0] upper;
        odd_len = $urandom_range(1, 14);
        use_odd = ($urandom_range(0, 3) == 0);
        upper = 2'($urandom);
        case ($urandom_range(0, 7))
            0, 1: put_value_ie(IE_TYPE_FTEID, use_odd ? odd_len : 9,
                               {upper, IFTYPE_S1U, rand_word(), rand_word()});
            2: put_value_ie(IE_TYPE_FTEID, use_odd ? odd_len : 9,
                            {upper, IFTYPE_S11, rand_word(), rand_word()});
            3: put_value_ie(IE_PAA, use_odd ? odd_len : 5, {rand_byte(), rand_word(), 32'h0});
            4: put_value_ie(IE_EBI, use_odd ? odd_len : 1, {rand_byte(), 64'h0});
            5: put_value_ie(IE_TYPE_FTEID, 9, {rand_byte(), rand_word(), rand_word()});
            6: put_value_ie(rand_byte(), odd_len, {rand_byte(), rand_word(), rand_word()});
            default: begin
                if (use_odd) begin
                    put_value_ie(rand_byte(), 0, 72'h0);
                end else begin
                    put_value_ie(IE_TYPE_FTEID, 9,
                                 {upper, IFTYPE_S11, rand_word(), rand_word()});
                end
            end
        endcase
    endtask

    task put_random_ie();
        int at;
        if ($urandom_range(0, 5) == 0) begin
            open_bearer(at);
            repeat ($urandom_range(1, 3)) put_leaf_ie();
            close_bearer(at);
        end else begin
            put_leaf_ie();
        end
    endtask

    task ship_message();
        t_in_word w;
        int       i;
        for (i = 0; i < msg.size(); i++) begin
            w.data_byte = msg[i];
            w.last_byte = (i == msg.size() - 1);
            pending_words.push_back(w);
        end
        bytes_queued += msg.size();
        msg.delete();
    endtask

    task finish_message();
        set_length(msg.size() - 4);
        ship_message();
    endtask

    task random_message(input int kind);
        logic [7:0]  mtype;
        logic [23:0] seq;
        int          body_len;
        int          keep;
        if (kind == KIND_TRUNC) begin
            repeat ($urandom_range(1, 11)) msg.push_back(rand_byte());
        end else begin
            mtype = $urandom_range(0, 1) ? TYPE_CREATE_RSP : TYPE_MODIFY_RSP;
            if (kind == KIND_NACK) begin
                mtype = rand_byte();
                if (mtype == TYPE_CREATE_RSP || mtype == TYPE_MODIFY_RSP) begin
                    mtype = mtype ^ 8'h40;
                end
            end
            seq = (kind == KIND_DUP) ? recent_seq : fresh_seq();
            put_header(mtype, seq);
            repeat ($urandom_range(0, 6)) put_random_ie();
            body_len = msg.size() - 4;
            if (kind == KIND_BAD_LEN) begin
                set_length($urandom_range(0, 1) ? $urandom_range(0, body_len)
                                                : $urandom_range(body_len, 65535));
            end else begin
                set_length(body_len);
            end
            if (kind == KIND_CUT) begin
                keep = $urandom_range(12, msg.size());
                while (msg.size() > keep) void'(msg.pop_back());
            end
        end
        ship_message();
    endtask

    task fill_random(input int budget);
        int stop_at;
        int r;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                random_message(KIND_GOOD);
            end else if (r < 70) begin
                random_message(KIND_NACK);
            end else if (r < 78) begin
                random_message(KIND_DUP);
            end else if (r < 85) begin
                random_message(KIND_TRUNC);
            end else if (r < 93) begin
                random_message(KIND_BAD_LEN);
            end else begin
                random_message(KIND_CUT);
            end
        end
    endtask

    task drain();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        fill_random(PHASE_BYTES);
        drain();
    endtask

    initial begin
        int at;
        last_seq_r = 24'h0;
        clear_message();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The stored sequence resets to zero, so sequence zero first is a duplicate.
        put_header(TYPE_CREATE_RSP, 24'h000000);
        put_value_ie(IE_EBI, 1, {8'h05, 64'h0});
        finish_message();

        // Every value at its all-ones extreme.
        put_header(TYPE_CREATE_RSP, 24'hFFFFFF);
        put_value_ie(IE_TYPE_FTEID, 9, {2'b11, IFTYPE_S1U, 32'hFFFFFFFF, 32'hFFFFFFFF});
        put_value_ie(IE_TYPE_FTEID, 9, {2'b11, IFTYPE_S11, 32'hFFFFFFFF, 32'hFFFFFFFF});
        put_value_ie(IE_PAA, 5, {8'hFF, 32'hFFFFFFFF, 32'h0});
        put_value_ie(IE_EBI, 1, {8'hFF, 64'h0});
        finish_message();

        put_header(TYPE_MODIFY_RSP, 24'hFFFFFF);
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S11, rand_word(), rand_word()});
        finish_message();

        // Modify response with a bearer context that carries the EBI and the S1-U F-TEID.
        put_header(TYPE_MODIFY_RSP, 24'h000001);
        open_bearer(at);
        put_value_ie(IE_EBI, 1, 72'h0);
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S1U, 64'h0});
        close_bearer(at);
        put_value_ie(IE_PAA, 5, 72'h0);
        finish_message();

        put_header(8'h00, fresh_seq());
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S1U, rand_word(), rand_word()});
        finish_message();
        put_header(8'hFF, fresh_seq());
        put_value_ie(IE_PAA, 5, {rand_byte(), rand_word(), 32'h0});
        finish_message();

        // Headers cut short at both ends of the truncated range.
        msg.push_back(rand_byte());
        ship_message();
        repeat (11) msg.push_back(rand_byte());
        ship_message();

        put_header(TYPE_CREATE_RSP, fresh_seq());
        finish_message();

        // A zero-length IE ends the walk; the S11 F-TEID after it is not taken.
        put_header(TYPE_CREATE_RSP, fresh_seq());
        put_value_ie(IE_PAA, 5, {rand_byte(), rand_word(), 32'h0});
        put_value_ie(IE_EBI, 0, 72'h0);
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S11, rand_word(), rand_word()});
        finish_message();

        // IEs too short for their values, then minimal and oversized ones.
        put_header(TYPE_CREATE_RSP, fresh_seq());
        put_value_ie(IE_TYPE_FTEID, 4, {2'b00, IFTYPE_S11, rand_word(), rand_word()});
        put_value_ie(IE_TYPE_FTEID, 8, {2'b00, IFTYPE_S1U, rand_word(), rand_word()});
        put_value_ie(IE_PAA, 4, {rand_byte(), rand_word(), 32'h0});
        put_value_ie(IE_TYPE_FTEID, 5, {2'b00, IFTYPE_S11, rand_word(), rand_word()});
        put_value_ie(IE_EBI, 2, {rand_byte(), 64'h0});
        put_value_ie(IE_TYPE_FTEID, 20, {2'b10, IFTYPE_S1U, rand_word(), rand_word()});
        finish_message();

        // The message ends inside the S1-U F-TEID, before its address is complete.
        put_header(TYPE_MODIFY_RSP, fresh_seq());
        put_value_ie(IE_EBI, 1, {rand_byte(), 64'h0});
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S1U, rand_word(), rand_word()});
        set_length(msg.size() - 4);
        repeat (3) void'(msg.pop_back());
        ship_message();

        // The length field covers only the PAA; the F-TEID lies beyond the bound.
        put_header(TYPE_CREATE_RSP, fresh_seq());
        put_value_ie(IE_PAA, 5, {rand_byte(), rand_word(), 32'h0});
        put_value_ie(IE_TYPE_FTEID, 9, {2'b00, IFTYPE_S11, rand_word(), rand_word()});
        set_length(17);
        ship_message();

        put_header(TYPE_CREATE_RSP, fresh_seq());
        put_value_ie(IE_TYPE_FTEID, 9, {2'b01, IFTYPE_S1U, rand_word(), rand_word()});
        set_length(65535);
        ship_message();

        // Other interface types are passed over; flag bits above the type are ignored.
        put_header(TYPE_MODIFY_RSP, fresh_seq());
        put_value_ie(IE_TYPE_FTEID, 9, {2'b11, 6'd2, rand_word(), rand_word()});
        put_value_ie(IE_TYPE_FTEID, 9, {2'b01, IFTYPE_S11, rand_word(), rand_word()});
        put_value_ie(IE_TYPE_FTEID, 9, {2'b10, 6'd63, rand_word(), rand_word()});
        finish_message();
        drain();

        run_phase(0, 0);
        run_phase(87, 0);
        run_phase(0, 87);
        run_phase(27, 27);

        // Short messages against a long receiver hold-off, so final words back up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) random_message($urandom_range(0, 1) ? KIND_TRUNC : KIND_NACK);
        hold_request = 1'b1;
        @(negedge i_clk);
        hold_request = 1'b0;
        drain();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        failures = failures + expected_results.size();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                decode_byte(data_byte, last_byte);
            end
            if (!in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid  <= 1'b1;
                    data_byte <= pending_words[0].data_byte;
                    last_byte <= pending_words[0].last_byte;
                    void'(pending_words.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("result word with none expected: status %0d mask %h",
                                 o_status, o_found_mask);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_found_mask !== want.found_mask ||
                        o_s1u_teid !== want.s1u_teid || o_sgw_ipv4 !== want.sgw_ipv4 ||
                        o_s11_teid !== want.s11_teid || o_ue_ipv4 !== want.ue_ipv4 ||
                        o_bearer_id !== want.bearer_id) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("mismatch (expected/actual): status %0d/%0d mask %h/%h",
                                     want.status, o_status, want.found_mask, o_found_mask);
                            $display("    s1u %h/%h sgw %h/%h s11 %h/%h ue %h/%h ebi %h/%h",
                                     want.s1u_teid, o_s1u_teid, want.sgw_ipv4, o_sgw_ipv4,
                                     want.s11_teid, o_s11_teid, want.ue_ipv4, o_ue_ipv4,
                                     want.bearer_id, o_bearer_id);
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

[files.f]
+incdir+design
design/gtpie_pkg.sv
design/gtpie_in_reg.sv
design/gtpie_core.sv
design/gtpie_out_reg.sv
design/gtpv2c_response_ie_extractor.sv
design/gtpie_checker.sv
tb/gtpv2c_response_ie_extractor_tb.sv
